>>> hw/rtl/mi3_pkg.sv
package mi3_pkg;

  localparam int NUM_ELEM = 9;
  localparam int NUM_PROD = 18;
  localparam int ELEM_W   = 32;
  localparam int PROD_W   = 64;
  localparam int COF_W    = 64;
  localparam int DET_W    = 98;
  localparam int DMAG_W   = 97;
  localparam int QUO_W    = 33;
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // product operand indexes; cofactor k is product 2k minus product 2k+1
  localparam logic [3:0] PROD_A [NUM_PROD] =
    '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
      4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] PROD_B [NUM_PROD] =
    '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
      4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  // cofactors used by the first-row determinant expansion
  localparam logic [3:0] DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  localparam logic [QUO_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [QUO_W-1:0] LIM_NEG = 33'h0_8000_0000;

  // classified matrix word passed from front to back
  typedef struct packed {
    logic [NUM_ELEM-1:0][COF_W-1:0] cmag;
    logic [NUM_ELEM-1:0]            neg;
    logic [DMAG_W-1:0]              dmag;
    logic                           singular;
  } item_t;

endpackage

>>> hw/rtl/mi3_front.sv
module mi3_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mi3_pkg::elem_t a [9],
  output logic          push,
  output mi3_pkg::item_t item,
  input  logic          full
);
  import mi3_pkg::*;

  logic [6:1] v;
  logic       en;

  logic signed [PROD_W-1:0] p1 [NUM_PROD];
  elem_t                    a1 [3];
  logic signed [COF_W-1:0]  c2 [NUM_ELEM];
  elem_t                    a2 [3];
  logic signed [63:0]       ph3 [3];
  logic signed [64:0]       pl3 [3];
  logic signed [COF_W-1:0]  c3 [NUM_ELEM];
  logic signed [DET_W-1:0]  t4 [3];
  logic signed [COF_W-1:0]  c4 [NUM_ELEM];
  logic signed [DET_W-1:0]  det5;
  logic signed [COF_W-1:0]  c5 [NUM_ELEM];
  item_t                    s6;

  // whole pipeline holds when its last word cannot enter the queue
  assign en       = !(v[6] && full);
  assign in_stall = !en;
  assign push     = v[6] && !full;
  assign item     = s6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // element products
      for (int i = 0; i < NUM_PROD; i++) begin
        p1[i] <= PROD_W'(a[PROD_A[i]]) * PROD_W'(a[PROD_B[i]]);
      end
      for (int j = 0; j < 3; j++) begin
        a1[j] <= a[j];
      end
      // cofactors
      for (int k = 0; k < NUM_ELEM; k++) begin
        c2[k] <= p1[2*k] - p1[2*k+1];
      end
      a2 <= a1;
      // determinant partial products, cofactor split in halves
      for (int j = 0; j < 3; j++) begin
        ph3[j] <= 64'(a2[j]) * 64'($signed(c2[DET_COF[j]][63:32]));
        pl3[j] <= 65'(a2[j]) * 65'($signed({1'b0, c2[DET_COF[j]][31:0]}));
      end
      c3 <= c2;
      // recombine halves
      for (int j = 0; j < 3; j++) begin
        t4[j] <= DET_W'($signed({ph3[j], 32'b0})) + DET_W'(pl3[j]);
      end
      c4 <= c3;
      // determinant
      det5 <= t4[0] + t4[1] + t4[2];
      c5   <= c4;
      // signs and magnitudes
      for (int k = 0; k < NUM_ELEM; k++) begin
        s6.cmag[k] <= c5[k][COF_W-1] ? COF_W'(-c5[k]) : COF_W'(c5[k]);
        s6.neg[k]  <= c5[k][COF_W-1] ^ det5[DET_W-1];
      end
      s6.dmag     <= det5[DET_W-1] ? DMAG_W'(-det5) : DMAG_W'(det5);
      s6.singular <= (det5 == '0);
    end
  end

endmodule

>>> hw/rtl/mi3_queue.sv
module mi3_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mi3_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output mi3_pkg::item_t rd_item
);
  import mi3_pkg::*;

  item_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

>>> hw/rtl/mi3_back.sv
module mi3_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mi3_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output mi3_pkg::elem_t r [9],
  output logic           singular,
  output logic           overflowed
);
  import mi3_pkg::*;

  localparam int NUM_W = COF_W + 2*FRAC_BITS;
  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = (HI_W > DMAG_W) ? HI_W : DMAG_W;
  localparam int REM_W = DMAG_W + 1;

  logic en;

  logic [QUO_W:0]        v;
  logic [REM_W-1:0]      rem  [QUO_W+1][NUM_ELEM];
  logic [QUO_W-1:0]      quo  [QUO_W+1][NUM_ELEM];
  logic [QUO_W-1:0]      low  [QUO_W+1][NUM_ELEM];
  logic [NUM_ELEM-1:0]   pov  [QUO_W+1];
  logic [NUM_ELEM-1:0]   neg  [QUO_W+1];
  logic [DMAG_W-1:0]     dmag [QUO_W+1];
  logic                  sng  [QUO_W+1];

  logic [REM_W-1:0]      rem_next [QUO_W][NUM_ELEM];
  logic [QUO_W-1:0]      quo_next [QUO_W][NUM_ELEM];

  logic [NUM_W-1:0]      num  [NUM_ELEM];
  logic [HI_W-1:0]       hi   [NUM_ELEM];

  assign en  = !(out_valid && out_stall);
  assign pop = en && q_valid;

  // numerator split: high part checked for overflow, low bits fed per step
  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      num[k] = {q_item.cmag[k], (2*FRAC_BITS)'(0)};
      hi[k]  = num[k][NUM_W-1:QUO_W];
    end
  end

  // one restoring step per stage
  always_comb begin
    logic [REM_W-1:0] t;
    for (int s = 0; s < QUO_W; s++) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        t = {rem[s][k][REM_W-2:0], low[s][k][QUO_W-1-s]};
        if (t >= {1'b0, dmag[s]}) begin
          rem_next[s][k] = t - {1'b0, dmag[s]};
          quo_next[s][k] = {quo[s][k][QUO_W-2:0], 1'b1};
        end else begin
          rem_next[s][k] = t;
          quo_next[s][k] = {quo[s][k][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[QUO_W-1:0], q_valid};
      out_valid <= v[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] val;
    logic             sat;
    logic             any_sat;
    if (en) begin
      // entry stage: overflow pre-check and first partial remainder
      for (int k = 0; k < NUM_ELEM; k++) begin
        pov[0][k] <= (CMP_W'(hi[k]) >= CMP_W'(q_item.dmag));
        rem[0][k] <= REM_W'(hi[k]);
        quo[0][k] <= '0;
        low[0][k] <= num[k][QUO_W-1:0];
      end
      neg[0]  <= q_item.neg;
      dmag[0] <= q_item.dmag;
      sng[0]  <= q_item.singular;
      // division stages
      for (int s = 0; s < QUO_W; s++) begin
        for (int k = 0; k < NUM_ELEM; k++) begin
          rem[s+1][k] <= rem_next[s][k];
          quo[s+1][k] <= quo_next[s][k];
          low[s+1][k] <= low[s][k];
        end
        pov[s+1]  <= pov[s];
        neg[s+1]  <= neg[s];
        dmag[s+1] <= dmag[s];
        sng[s+1]  <= sng[s];
      end
      // saturation, sign and singular override into the output word
      any_sat = 1'b0;
      for (int k = 0; k < NUM_ELEM; k++) begin
        lim = neg[QUO_W][k] ? LIM_NEG : LIM_POS;
        sat = pov[QUO_W][k] || (quo[QUO_W][k] > lim);
        val = sat ? lim : quo[QUO_W][k];
        any_sat = any_sat | sat;
        if (sng[QUO_W]) begin
          r[k] <= '0;
        end else if (neg[QUO_W][k]) begin
          r[k] <= elem_t'(QUO_W'(0) - val);
        end else begin
          r[k] <= elem_t'(val);
        end
      end
      singular   <= sng[QUO_W];
      overflowed <= !sng[QUO_W] && any_sat;
    end
  end

endmodule

>>> hw/rtl/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by adjugate and exact division. Elements are
// signed 32-bit words with FRAC_BITS fraction bits; each inverse entry is the
// cofactor scaled by 2^(2*FRAC_BITS) divided by the determinant, truncated
// toward zero, saturated to 32 bits (overflowed set), or all zero with
// singular set when the determinant is zero. One matrix word is accepted per
// cycle and one result word leaves per cycle when neither side stalls. A word
// passes a 6-stage front that computes products, cofactors and the
// determinant, then a 4-entry queue, and then the back, which runs nine
// 33-stage restoring dividers (one quotient bit per stage) ahead of the
// output register. The two halves stall independently.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  a11,
  input  logic signed [31:0]  a12,
  input  logic signed [31:0]  a13,
  input  logic signed [31:0]  a21,
  input  logic signed [31:0]  a22,
  input  logic signed [31:0]  a23,
  input  logic signed [31:0]  a31,
  input  logic signed [31:0]  a32,
  input  logic signed [31:0]  a33,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  r11,
  output logic signed [31:0]  r12,
  output logic signed [31:0]  r13,
  output logic signed [31:0]  r21,
  output logic signed [31:0]  r22,
  output logic signed [31:0]  r23,
  output logic signed [31:0]  r31,
  output logic signed [31:0]  r32,
  output logic signed [31:0]  r33,
  output logic                singular,
  output logic                overflowed
);
  import mi3_pkg::*;

  elem_t a [NUM_ELEM];
  elem_t r [NUM_ELEM];
  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;

  assign a = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};

  mi3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .a        (a),
    .push     (push),
    .item     (push_item),
    .full     (full)
  );

  mi3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (push_item),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_item  (pop_item)
  );

  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .r          (r),
    .singular   (singular),
    .overflowed (overflowed)
  );

  assign r11 = r[0];
  assign r12 = r[1];
  assign r13 = r[2];
  assign r21 = r[3];
  assign r22 = r[4];
  assign r23 = r[5];
  assign r31 = r[6];
  assign r32 = r[7];
  assign r33 = r[8];

endmodule
